### hw/rtl/sitp_pkg.sv
// Shared types and constants for the segment intersection core.
`default_nettype none
package sitp_pkg;
    // Width of each crossing coordinate on the result bus.
    localparam int OUT_W = 24;
    // Quotient bits resolved by the divider; one more than OUT_W catches saturation.
    localparam int QB = OUT_W + 1;

    // Sideband that travels with each pair through the pipeline.
    typedef struct packed {
        logic vld;
        logic hit;
        logic pv;
    } side_t;
endpackage
`default_nettype wire

### hw/rtl/segment_intersect_test_and_point_core.sv
// Top level: segment pair intersection test and crossing point, fully pipelined.
// One pair of segments enters per clock and one result beat leaves per pair, in order.
// The pipeline has three front stages (differences, products, sums), three numerator
// stages, one divider setup stage, one stage per quotient bit, and the output register.
// Throughput is one beat per cycle; the whole pipeline holds when the output register
// is full and not taken, so s_tready drops only then. Orientation signs come from exact
// cross products; the crossing point is found by Cramer's rule and given in signed fixed
// point with FRAC_BITS fraction bits, truncated toward zero and saturated to 24 bits. The
// point and point_valid are zero unless the segments cross properly with a nonzero
// determinant. Coordinates use the low COORD_BITS bits of each 16-bit field, signed.
`default_nettype none
module segment_intersect_test_and_point_core
    import sitp_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // slave side
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // fields from bit 0: first_start_x, first_start_y, first_end_x, first_end_y,
    //   second_start_x, second_start_y, second_end_x, second_end_y (16 bits each)
    input  wire logic [127:0] s_tdata,
    // master side
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // fields from bit 0: intersects (1), cross_x_q8 (24), cross_y_q8 (24), zero pad (7)
    output logic [55:0]       m_tdata,
    // fields from bit 0: point_valid (1)
    output logic [0:0]        m_tuser
);
    localparam int DW   = COORD_BITS + 1;
    localparam int CW   = 2 * DW + 1;
    localparam int NSW  = 3 * COORD_BITS + FRAC_BITS + 6;
    localparam logic [QB-1:0] LIM = QB'(1) << (OUT_W - 1);

    // whole pipeline advances together; held only by a full, untaken output register
    logic ce;
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // coordinates: low COORD_BITS of each field (zero-extended when wider than the field)
    logic signed [COORD_BITS-1:0] x1, y1, x2, y2, x3, y3, x4, y4;

    always_comb begin
        x1 = COORD_BITS'(s_tdata[15:0]);
        y1 = COORD_BITS'(s_tdata[31:16]);
        x2 = COORD_BITS'(s_tdata[47:32]);
        y2 = COORD_BITS'(s_tdata[63:48]);
        x3 = COORD_BITS'(s_tdata[79:64]);
        y3 = COORD_BITS'(s_tdata[95:80]);
        x4 = COORD_BITS'(s_tdata[111:96]);
        y4 = COORD_BITS'(s_tdata[127:112]);
    end

    logic                 g_vld;
    logic signed [DW-1:0] a1, b1, a2, b2;
    logic signed [CW-1:0] c1, c2, det, v1, v2, v3, v4;
    logic [3:0]           box;

    sitp_geom #(
        .COORD_BITS(COORD_BITS)
    ) u_geom (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .in_vld  (s_tvalid),
        .x1      (x1),
        .y1      (y1),
        .x2      (x2),
        .y2      (y2),
        .x3      (x3),
        .y3      (y3),
        .x4      (x4),
        .y4      (y4),
        .out_vld (g_vld),
        .a1      (a1),
        .b1      (b1),
        .a2      (a2),
        .b2      (b2),
        .c1      (c1),
        .c2      (c2),
        .det     (det),
        .v1      (v1),
        .v2      (v2),
        .v3      (v3),
        .v4      (v4),
        .box     (box)
    );

    side_t           n_side;
    logic            negx, negy;
    logic [NSW-1:0]  nxmag, nymag;
    logic [CW-1:0]   dmag;

    sitp_numer #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_numer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .in_vld  (g_vld),
        .a1      (a1),
        .b1      (b1),
        .a2      (a2),
        .b2      (b2),
        .c1      (c1),
        .c2      (c2),
        .det     (det),
        .v1      (v1),
        .v2      (v2),
        .v3      (v3),
        .v4      (v4),
        .box     (box),
        .side    (n_side),
        .negx    (negx),
        .negy    (negy),
        .nxmag   (nxmag),
        .nymag   (nymag),
        .dmag    (dmag)
    );

    // x and y share control; each divider carries its own copy of the sideband
    side_t          dx_side, dy_side;
    logic           dx_neg, dy_neg, dx_ovf, dy_ovf;
    logic [QB-1:0]  qx, qy;

    sitp_div #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_side  (n_side),
        .in_neg   (negx),
        .n_mag    (nxmag),
        .d_mag    (dmag),
        .out_side (dx_side),
        .out_neg  (dx_neg),
        .out_ovf  (dx_ovf),
        .quo      (qx)
    );

    sitp_div #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_side  (n_side),
        .in_neg   (negy),
        .n_mag    (nymag),
        .d_mag    (dmag),
        .out_side (dy_side),
        .out_neg  (dy_neg),
        .out_ovf  (dy_ovf),
        .quo      (qy)
    );

    // sign and saturate a quotient magnitude into the signed output range
    function automatic logic [OUT_W-1:0] sat_out(input logic pv, input logic neg,
                                                 input logic ovf, input logic [QB-1:0] q);
        logic [OUT_W-1:0] r;
        r = '0;
        if (!pv) begin
            r = '0;
        end else if (neg) begin
            r = (ovf || q > LIM) ? OUT_W'(QB'(0) - LIM) : OUT_W'(QB'(0) - q);
        end else begin
            r = (ovf || q >= LIM) ? OUT_W'(LIM - QB'(1)) : OUT_W'(q);
        end
        return r;
    endfunction

    logic             m_tvalid_reg;
    logic             hit_reg;
    logic             pv_reg;
    logic [OUT_W-1:0] px_reg, py_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            m_tvalid_reg <= dx_side.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            hit_reg <= dx_side.hit;
            pv_reg  <= dx_side.pv;
            px_reg  <= sat_out(dx_side.pv, dx_neg, dx_ovf, qx);
            py_reg  <= sat_out(dx_side.pv, dy_neg, dy_ovf, qy);
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {7'd0, py_reg, px_reg, hit_reg};
    assign m_tuser[0] = pv_reg;

    // a crossing point only comes from a proper crossing
    a_pv_implies_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && pv_reg |-> hit_reg)
        else $error("point_valid without intersects");

    // both dividers stay in lockstep
    a_div_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        dx_side.vld == dy_side.vld)
        else $error("divider valid bits diverged");

    // no point, no coordinates
    a_zero_point: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !pv_reg |-> px_reg == '0 && py_reg == '0)
        else $error("nonzero point without point_valid");

    // a held result is not overwritten
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tready |=> $stable(px_reg) && $stable(py_reg) && m_tvalid_reg)
        else $error("result changed while stalled");
endmodule
`default_nettype wire

### hw/rtl/sitp_geom.sv
// Front stages: differences, products and sums for orientations, line terms and determinant.
`default_nettype none
module sitp_geom #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             ce,
    input  wire logic                             in_vld,
    input  wire logic signed [COORD_BITS-1:0]     x1,
    input  wire logic signed [COORD_BITS-1:0]     y1,
    input  wire logic signed [COORD_BITS-1:0]     x2,
    input  wire logic signed [COORD_BITS-1:0]     y2,
    input  wire logic signed [COORD_BITS-1:0]     x3,
    input  wire logic signed [COORD_BITS-1:0]     y3,
    input  wire logic signed [COORD_BITS-1:0]     x4,
    input  wire logic signed [COORD_BITS-1:0]     y4,
    output logic                                  out_vld,
    output logic signed [COORD_BITS:0]            a1,
    output logic signed [COORD_BITS:0]            b1,
    output logic signed [COORD_BITS:0]            a2,
    output logic signed [COORD_BITS:0]            b2,
    output logic signed [2*COORD_BITS+2:0]        c1,
    output logic signed [2*COORD_BITS+2:0]        c2,
    output logic signed [2*COORD_BITS+2:0]        det,
    output logic signed [2*COORD_BITS+2:0]        v1,
    output logic signed [2*COORD_BITS+2:0]        v2,
    output logic signed [2*COORD_BITS+2:0]        v3,
    output logic signed [2*COORD_BITS+2:0]        v4,
    output logic [3:0]                            box
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    // stage 1: differences and box tests
    logic                 vld1_reg;
    logic signed [DW-1:0] a1_1_reg, b1_1_reg, a2_1_reg, b2_1_reg;
    logic signed [DW-1:0] e1x_reg, e1y_reg, e2x_reg, e2y_reg;
    logic signed [DW-1:0] e3x_reg, e3y_reg, e4x_reg, e4y_reg;
    logic signed [COORD_BITS-1:0] x1_1_reg, y1_1_reg, x3_1_reg, y3_1_reg;
    logic [3:0]           box1_reg;

    function automatic logic in_span(input logic signed [COORD_BITS-1:0] p,
                                     input logic signed [COORD_BITS-1:0] q,
                                     input logic signed [COORD_BITS-1:0] r);
        in_span = (q >= p && q <= r) || (q >= r && q <= p);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (ce) begin
            vld1_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a1_1_reg <= DW'(y2) - DW'(y1);
            b1_1_reg <= DW'(x1) - DW'(x2);
            a2_1_reg <= DW'(y4) - DW'(y3);
            b2_1_reg <= DW'(x3) - DW'(x4);
            e1x_reg  <= DW'(x3) - DW'(x2);
            e1y_reg  <= DW'(y3) - DW'(y2);
            e2x_reg  <= DW'(x4) - DW'(x2);
            e2y_reg  <= DW'(y4) - DW'(y2);
            e3x_reg  <= DW'(x1) - DW'(x4);
            e3y_reg  <= DW'(y1) - DW'(y4);
            e4x_reg  <= DW'(x2) - DW'(x4);
            e4y_reg  <= DW'(y2) - DW'(y4);
            x1_1_reg <= x1;
            y1_1_reg <= y1;
            x3_1_reg <= x3;
            y3_1_reg <= y3;
            box1_reg[0] <= in_span(x1, x3, x2) && in_span(y1, y3, y2);
            box1_reg[1] <= in_span(x1, x4, x2) && in_span(y1, y4, y2);
            box1_reg[2] <= in_span(x3, x1, x4) && in_span(y3, y1, y4);
            box1_reg[3] <= in_span(x3, x2, x4) && in_span(y3, y2, y4);
        end
    end

    // stage 2: products
    logic                 vld2_reg;
    logic signed [DW-1:0] a1_2_reg, b1_2_reg, a2_2_reg, b2_2_reg;
    logic signed [PW-1:0] po1a_reg, po1b_reg, po2a_reg, po2b_reg;
    logic signed [PW-1:0] po3a_reg, po3b_reg, po4a_reg, po4b_reg;
    logic signed [PW-1:0] pc1a_reg, pc1b_reg, pc2a_reg, pc2b_reg;
    logic signed [PW-1:0] pda_reg, pdb_reg;
    logic [3:0]           box2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (ce) begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a1_2_reg <= a1_1_reg;
            b1_2_reg <= b1_1_reg;
            a2_2_reg <= a2_1_reg;
            b2_2_reg <= b2_1_reg;
            po1a_reg <= PW'(a1_1_reg) * PW'(e1x_reg);
            po1b_reg <= PW'(b1_1_reg) * PW'(e1y_reg);
            po2a_reg <= PW'(a1_1_reg) * PW'(e2x_reg);
            po2b_reg <= PW'(b1_1_reg) * PW'(e2y_reg);
            po3a_reg <= PW'(a2_1_reg) * PW'(e3x_reg);
            po3b_reg <= PW'(b2_1_reg) * PW'(e3y_reg);
            po4a_reg <= PW'(a2_1_reg) * PW'(e4x_reg);
            po4b_reg <= PW'(b2_1_reg) * PW'(e4y_reg);
            pc1a_reg <= PW'(a1_1_reg) * PW'(x1_1_reg);
            pc1b_reg <= PW'(b1_1_reg) * PW'(y1_1_reg);
            pc2a_reg <= PW'(a2_1_reg) * PW'(x3_1_reg);
            pc2b_reg <= PW'(b2_1_reg) * PW'(y3_1_reg);
            pda_reg  <= PW'(a1_1_reg) * PW'(b2_1_reg);
            pdb_reg  <= PW'(a2_1_reg) * PW'(b1_1_reg);
            box2_reg <= box1_reg;
        end
    end

    // stage 3: sums
    logic vld3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld3_reg <= 1'b0;
        end else if (ce) begin
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a1  <= a1_2_reg;
            b1  <= b1_2_reg;
            a2  <= a2_2_reg;
            b2  <= b2_2_reg;
            v1  <= SW'(po1a_reg) + SW'(po1b_reg);
            v2  <= SW'(po2a_reg) + SW'(po2b_reg);
            v3  <= SW'(po3a_reg) + SW'(po3b_reg);
            v4  <= SW'(po4a_reg) + SW'(po4b_reg);
            c1  <= SW'(pc1a_reg) + SW'(pc1b_reg);
            c2  <= SW'(pc2a_reg) + SW'(pc2b_reg);
            det <= SW'(pda_reg) - SW'(pdb_reg);
            box <= box2_reg;
        end
    end

    assign out_vld = vld3_reg;
endmodule
`default_nettype wire

### hw/rtl/sitp_numer.sv
// Middle stages: hit decision, Cramer numerators and magnitudes for the divider.
`default_nettype none
module sitp_numer
    import sitp_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   ce,
    input  wire logic                                   in_vld,
    input  wire logic signed [COORD_BITS:0]             a1,
    input  wire logic signed [COORD_BITS:0]             b1,
    input  wire logic signed [COORD_BITS:0]             a2,
    input  wire logic signed [COORD_BITS:0]             b2,
    input  wire logic signed [2*COORD_BITS+2:0]         c1,
    input  wire logic signed [2*COORD_BITS+2:0]         c2,
    input  wire logic signed [2*COORD_BITS+2:0]         det,
    input  wire logic signed [2*COORD_BITS+2:0]         v1,
    input  wire logic signed [2*COORD_BITS+2:0]         v2,
    input  wire logic signed [2*COORD_BITS+2:0]         v3,
    input  wire logic signed [2*COORD_BITS+2:0]         v4,
    input  wire logic [3:0]                             box,
    output side_t                                       side,
    output logic                                        negx,
    output logic                                        negy,
    output logic [3*COORD_BITS+FRAC_BITS+5:0]           nxmag,
    output logic [3*COORD_BITS+FRAC_BITS+5:0]           nymag,
    output logic [2*COORD_BITS+2:0]                     dmag
);
    localparam int DW   = COORD_BITS + 1;
    localparam int CW   = 2 * DW + 1;
    localparam int MW   = CW + DW;
    localparam int NW   = MW + 1;
    localparam int NSW  = NW + FRAC_BITS;
    // magnitude bus width toward the divider
    localparam int OMW  = NSW + 1;

    // orientation code: {zero, negative}
    function automatic logic [1:0] ocode(input logic signed [CW-1:0] v);
        ocode = {v == '0, v[CW-1]};
    endfunction

    logic [1:0] o1, o2, o3, o4;
    logic       general;

    always_comb begin
        o1 = ocode(v1);
        o2 = ocode(v2);
        o3 = ocode(v3);
        o4 = ocode(v4);
        general = (o1 != o2) && (o3 != o4);
    end

    // stage 4: numerator products, hit decision
    side_t                side4_reg;
    logic signed [MW-1:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [CW-1:0] det4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side4_reg.vld <= 1'b0;
        end else if (ce) begin
            side4_reg.vld <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            side4_reg.hit <= general
                || (o1[1] && box[0]) || (o2[1] && box[1])
                || (o3[1] && box[2]) || (o4[1] && box[3]);
            side4_reg.pv  <= general && (det != '0);
            m1_reg   <= MW'(c1) * MW'(b2);
            m2_reg   <= MW'(c2) * MW'(b1);
            m3_reg   <= MW'(a1) * MW'(c2);
            m4_reg   <= MW'(a2) * MW'(c1);
            det4_reg <= det;
        end
    end

    // stage 5: numerators
    side_t                side5_reg;
    logic signed [NW-1:0] nx5_reg, ny5_reg;
    logic signed [CW-1:0] det5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side5_reg.vld <= 1'b0;
        end else if (ce) begin
            side5_reg.vld <= side4_reg.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            side5_reg.hit <= side4_reg.hit;
            side5_reg.pv  <= side4_reg.pv;
            nx5_reg  <= NW'(m1_reg) - NW'(m2_reg);
            ny5_reg  <= NW'(m3_reg) - NW'(m4_reg);
            det5_reg <= det4_reg;
        end
    end

    // stage 6: scale to fixed point, split sign and magnitude
    logic signed [NSW-1:0] nxs, nys;

    always_comb begin
        nxs = NSW'(nx5_reg) <<< FRAC_BITS;
        nys = NSW'(ny5_reg) <<< FRAC_BITS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side.vld <= 1'b0;
        end else if (ce) begin
            side.vld <= side5_reg.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            side.hit <= side5_reg.hit;
            side.pv  <= side5_reg.pv;
            negx  <= nx5_reg[NW-1] ^ det5_reg[CW-1];
            negy  <= ny5_reg[NW-1] ^ det5_reg[CW-1];
            nxmag <= OMW'($unsigned(nxs[NSW-1] ? NSW'(NSW'(0) - nxs) : NSW'(nxs)));
            nymag <= OMW'($unsigned(nys[NSW-1] ? NSW'(NSW'(0) - nys) : NSW'(nys)));
            dmag  <= det5_reg[CW-1] ? CW'(CW'(0) - det5_reg) : CW'(det5_reg);
        end
    end
endmodule
`default_nettype wire

### hw/rtl/sitp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`default_nettype none
module sitp_div
    import sitp_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   ce,
    input  wire side_t                                  in_side,
    input  wire logic                                   in_neg,
    input  wire logic [3*COORD_BITS+FRAC_BITS+5:0]      n_mag,
    input  wire logic [2*COORD_BITS+2:0]                d_mag,
    output side_t                                       out_side,
    output logic                                        out_neg,
    output logic                                        out_ovf,
    output logic [QB-1:0]                               quo
);
    localparam int DETW = 2 * COORD_BITS + 3;
    localparam int NSW  = 3 * COORD_BITS + FRAC_BITS + 6;
    localparam int RW   = DETW + 1;
    localparam int CMPW = (NSW > DETW) ? NSW : DETW;

    side_t               side_reg [0:QB];
    logic                neg_reg  [0:QB];
    logic                ovf_reg  [0:QB];
    logic [RW-1:0]       rem_reg  [0:QB];
    logic [QB-1:0]       nlo_reg  [0:QB];
    logic [QB-1:0]       q_reg    [0:QB];
    logic [DETW-1:0]     dm_reg   [0:QB];

    // stage 0: overflow test and initial remainder (below the divisor unless overflow is set)
    logic [CMPW-1:0] nhi;

    always_comb begin
        nhi = CMPW'(n_mag >> QB);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg[0].vld <= 1'b0;
        end else if (ce) begin
            side_reg[0].vld <= in_side.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            side_reg[0].hit <= in_side.hit;
            side_reg[0].pv  <= in_side.pv;
            neg_reg[0] <= in_neg;
            ovf_reg[0] <= nhi >= CMPW'(d_mag);
            rem_reg[0] <= RW'(n_mag >> QB);
            nlo_reg[0] <= n_mag[QB-1:0];
            q_reg[0]   <= '0;
            dm_reg[0]  <= d_mag;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_step
        logic [RW-1:0] rsh;
        logic          take;

        always_comb begin
            rsh  = {rem_reg[k-1][RW-2:0], nlo_reg[k-1][QB-1]};
            take = rsh >= {1'b0, dm_reg[k-1]};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg[k].vld <= 1'b0;
            end else if (ce) begin
                side_reg[k].vld <= side_reg[k-1].vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                side_reg[k].hit <= side_reg[k-1].hit;
                side_reg[k].pv  <= side_reg[k-1].pv;
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                rem_reg[k] <= take ? (rsh - {1'b0, dm_reg[k-1]}) : rsh;
                nlo_reg[k] <= nlo_reg[k-1] << 1;
                q_reg[k]   <= {q_reg[k-1][QB-2:0], take};
                dm_reg[k]  <= dm_reg[k-1];
            end
        end
    end

    assign out_side = side_reg[QB];
    assign out_neg  = neg_reg[QB];
    assign out_ovf  = ovf_reg[QB];
    assign quo      = q_reg[QB];
endmodule
`default_nettype wire

### tb/segment_intersect_test_and_point_core_tb.sv
// Testbench for the segment pair intersection test and crossing point core.
`timescale 1ns / 1ps
`default_nettype none
module segment_intersect_test_and_point_core_tb;
    import sitp_pkg::*;

    // Core latency from input beat to result beat; drain allows a margin on top.
    localparam int LATENCY = QB + 8;

    typedef struct packed {
        logic signed [15:0] y4, x4, y3, x3, y2, x2, y1, x1;
    } seg_pair_t;

    typedef struct {
        logic               hit;
        logic               pv;
        logic signed [23:0] px;
        logic signed [23:0] py;
    } crossing_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [55:0]  m_tdata;
    logic [0:0]   m_tuser;

    crossing_t expected_crossings[$];
    int        mismatch_count = 0;
    int        beat_count = 0;
    // Chance per cycle that the receiver starts a stall; 0 gives full throughput.
    int        stall_pct = 30;
    int        gap_pct = 30;
    int        stall_left = 0;

    always #4 aclk = ~aclk;

    segment_intersect_test_and_point_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // Orientation of r against line p->q: 0 collinear, 1 one side, 2 the other.
    function automatic int orientation(longint px, longint py, longint qx, longint qy,
                                       longint rx, longint ry);
        longint v;
        v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
        return (v == 0) ? 0 : ((v > 0) ? 1 : 2);
    endfunction

    // q inside the bounding box spanned by p and r.
    function automatic bit in_bbox(longint px, longint py, longint qx, longint qy,
                                   longint rx, longint ry);
        longint xlo, xhi, ylo, yhi;
        xlo = (px < rx) ? px : rx;
        xhi = (px < rx) ? rx : px;
        ylo = (py < ry) ? py : ry;
        yhi = (py < ry) ? ry : py;
        return qx >= xlo && qx <= xhi && qy >= ylo && qy <= yhi;
    endfunction

    // Truncating divide, saturated to the 24-bit result range.
    function automatic logic signed [23:0] q8_quotient(logic signed [127:0] n,
                                                       logic signed [127:0] d);
        logic signed [127:0] q;
        q = n / d;
        if (q > 128'sd8388607) return 24'sh7fffff;
        if (q < -128'sd8388608) return 24'sh800000;
        return q[23:0];
    endfunction

    function automatic crossing_t predict_crossing(seg_pair_t s);
        crossing_t r;
        longint x1, y1, x2, y2, x3, y3, x4, y4;
        longint a1, b1, c1, a2, b2, c2, det;
        logic signed [127:0] nx, ny;
        int o1, o2, o3, o4;
        bit general;
        x1 = s.x1; y1 = s.y1; x2 = s.x2; y2 = s.y2;
        x3 = s.x3; y3 = s.y3; x4 = s.x4; y4 = s.y4;
        o1 = orientation(x1, y1, x2, y2, x3, y3);
        o2 = orientation(x1, y1, x2, y2, x4, y4);
        o3 = orientation(x3, y3, x4, y4, x1, y1);
        o4 = orientation(x3, y3, x4, y4, x2, y2);
        general = (o1 != o2) && (o3 != o4);
        r.hit = general
            || (o1 == 0 && in_bbox(x1, y1, x3, y3, x2, y2))
            || (o2 == 0 && in_bbox(x1, y1, x4, y4, x2, y2))
            || (o3 == 0 && in_bbox(x3, y3, x1, y1, x4, y4))
            || (o4 == 0 && in_bbox(x3, y3, x2, y2, x4, y4));
        r.pv = 1'b0;
        r.px = '0;
        r.py = '0;
        if (general) begin
            a1 = y2 - y1; b1 = x1 - x2; c1 = a1 * x1 + b1 * y1;
            a2 = y4 - y3; b2 = x3 - x4; c2 = a2 * x3 + b2 * y3;
            det = a1 * b2 - a2 * b1;
            if (det != 0) begin
                // c terms stay below 2^32, products below 2^48: widen before multiplying
                nx = (128'(signed'(c1)) * 128'(signed'(b2))
                      - 128'(signed'(c2)) * 128'(signed'(b1))) <<< 8;
                ny = (128'(signed'(a1)) * 128'(signed'(c2))
                      - 128'(signed'(a2)) * 128'(signed'(c1))) <<< 8;
                r.px = q8_quotient(nx, 128'(signed'(det)));
                r.py = q8_quotient(ny, 128'(signed'(det)));
                r.pv = 1'b1;
            end
        end
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(99) < 5) return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    task automatic send_pair(seg_pair_t s);
        int g;
        if ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            g = gap_len();
            repeat (g) @(posedge aclk);
        end
        s_tdata  <= s;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_crossings.push_back(predict_crossing(s));
    endtask

    task automatic release_bus();
        s_tvalid <= 1'b0;
    endtask

    // Receiver: stalls for random stretches, compares each beat with the oldest expectation.
    always @(posedge aclk) begin
        crossing_t e;
        if (aresetn && m_tvalid && m_tready) begin
            beat_count++;
            if (expected_crossings.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat %h / %b", m_tdata, m_tuser);
            end else begin
                e = expected_crossings.pop_front();
                if (m_tdata[0] !== e.hit || m_tuser[0] !== e.pv ||
                    m_tdata[24:1] !== e.px || m_tdata[48:25] !== e.py ||
                    m_tdata[55:49] !== 7'd0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"beat %0d: exp hit %b pv %b x %0d y %0d, ",
                                  "got hit %b pv %b x %0d y %0d pad %h"},
                                 beat_count, e.hit, e.pv, e.px, e.py, m_tdata[0], m_tuser[0],
                                 $signed(m_tdata[24:1]), $signed(m_tdata[48:25]),
                                 m_tdata[55:49]);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(99) < stall_pct) begin
            stall_left = gap_len() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic seg_pair_t make_pair(int x1, int y1, int x2, int y2,
                                            int x3, int y3, int x4, int y4);
        seg_pair_t s;
        s.x1 = 16'(x1); s.y1 = 16'(y1); s.x2 = 16'(x2); s.y2 = 16'(y2);
        s.x3 = 16'(x3); s.y3 = 16'(y3); s.x4 = 16'(x4); s.y4 = 16'(y4);
        return s;
    endfunction

    function automatic logic signed [15:0] rand_coord(int range_sel);
        case (range_sel)
            0: return 16'($urandom_range(16, 0) - 8);
            1: return 16'($urandom_range(512, 0) - 256);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic test_directed();
        // proper crossing, X shape
        send_pair(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
        // crossing with fractional point
        send_pair(make_pair(0, 0, 3, 1, 0, 1, 1, 0));
        // negative coordinates crossing
        send_pair(make_pair(-5, -7, 9, 3, -8, 6, 4, -9));
        // disjoint parallel
        send_pair(make_pair(0, 0, 10, 0, 0, 5, 10, 5));
        // collinear overlap
        send_pair(make_pair(0, 0, 10, 0, 5, 0, 15, 0));
        // collinear disjoint
        send_pair(make_pair(0, 0, 4, 0, 6, 0, 9, 0));
        // touching at one endpoint (T junction)
        send_pair(make_pair(0, 0, 10, 0, 5, 0, 5, 8));
        // shared endpoint
        send_pair(make_pair(0, 0, 4, 4, 4, 4, 8, 0));
        // degenerate point segment on the other segment
        send_pair(make_pair(3, 3, 3, 3, 0, 0, 6, 6));
        // degenerate point off the segment
        send_pair(make_pair(3, 4, 3, 4, 0, 0, 6, 6));
        // both degenerate and equal
        send_pair(make_pair(-2, 7, -2, 7, -2, 7, -2, 7));
        // lines cross but segments do not reach
        send_pair(make_pair(0, 0, 1, 1, 10, 0, 9, 1));
        // extremes of the coordinate range
        send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_pair(make_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32766));
        send_pair(make_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767));
        send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768));
        send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_pair(make_pair(-1, -1, -1, -1, 0, 0, 0, 0));
        // near-parallel long segments: large point magnitude
        send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, -32767, 32767, 32767));
        send_pair(make_pair(-32768, 0, 32767, 0, -32768, -1, 32767, 1));
        release_bus();
    endtask

    task automatic test_random(int n);
        seg_pair_t s;
        int k, sel;
        for (k = 0; k < n; k++) begin
            sel = $urandom_range(2);
            s.x1 = rand_coord(sel); s.y1 = rand_coord(sel);
            s.x2 = rand_coord(sel); s.y2 = rand_coord(sel);
            s.x3 = rand_coord(sel); s.y3 = rand_coord(sel);
            s.x4 = rand_coord(sel); s.y4 = rand_coord(sel);
            case ($urandom_range(9))
                // roughly collinear: second segment along first's line, up to rounding
                0: begin
                    s.x3 = 16'(s.x1 + 2 * (s.x2 - s.x1) / 3);
                    s.y3 = 16'(s.y1 + 2 * (s.y2 - s.y1) / 3);
                    s.x4 = s.x2; s.y4 = s.y2;
                end
                1: begin s.x3 = s.x1; s.y3 = s.y1; end      // shared endpoint
                2: begin s.x2 = s.x1; s.y2 = s.y1; end      // degenerate first
                3: s = $urandom() ? s : ~s;                // bits flipped only when $urandom() returns zero
                default: ;
            endcase
            send_pair(s);
        end
        release_bus();
    endtask

    task automatic wait_drained();
        while (expected_crossings.size() != 0) @(posedge aclk);
    endtask

    task automatic test_full_rate(int n);
        // no gaps on either side, then pause until the pipeline drains
        gap_pct = 0;
        stall_pct = 0;
        test_random(n);
        wait_drained();
        gap_pct = 30;
        stall_pct = 30;
    endtask

    task automatic test_backpressure(int n);
        // heavy receiver stalls fill the pipeline and drop s_tready
        stall_pct = 85;
        test_random(n);
        stall_pct = 30;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(400);
        wait_drained();
        test_full_rate(300);
        test_backpressure(200);
        test_random(200);
        wait_drained();
        repeat (LATENCY + 10) @(posedge aclk);
        if (mismatch_count == 0 && expected_crossings.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
hw/rtl/sitp_pkg.sv
hw/rtl/sitp_geom.sv
hw/rtl/sitp_numer.sv
hw/rtl/sitp_div.sv
hw/rtl/segment_intersect_test_and_point_core.sv
tb/segment_intersect_test_and_point_core_tb.sv
